// ===== rtl/wmll_pkg.sv =====
// Types and constant tables for the Web Mercator pixel projection pipeline.
// Tables are built at elaboration by integer series; no dependencies.
package wmll_pkg;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic        [4:0]  zoom;
    } in_item_t;

    typedef struct packed {
        logic [30:0] pixel_x;
        logic [30:0] pixel_y;
        logic [22:0] tile_x;
        logic [22:0] tile_y;
        logic        clipped;
    } out_item_t;

    // sideband that rides along every stage; rem/xq hold the x long division
    typedef struct packed {
        logic [4:0]  zm;
        logic        clip;
        logic [31:0] rem;
        logic [40:0] xq;
    } side_t;

    localparam int QF = 40;
    localparam int CW = 44;
    localparam logic [31:0] LON_SPAN  = 32'd3600000000;
    localparam logic [63:0] RAD_DEN   = 64'd36000000000;
    localparam logic [63:0] RAD_HALF  = 64'd18000000000;

    // restoring division, elaboration use only
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sum over odd j of (+-)2^(62-j*k)/j
    function automatic longint series_pow2(input int k, input bit alt);
        longint s;
        longint term;
        s = 0;
        for (int j = 1; j * k <= 62; j += 2) begin
            term = longint'(udiv(64'd1 << (62 - j * k), 64'(j)));
            if (alt && j[1]) s = s - term;
            else s = s + term;
        end
        return s;
    endfunction

    // sum over odd j of (+-)(1/n)^j/j in Q62
    function automatic longint series_recip(input int n, input bit alt);
        logic [63:0] p;
        logic [63:0] nn;
        longint s;
        longint term;
        nn = 64'(n) * 64'(n);
        p = udiv(64'd1 << 62, 64'(n));
        s = 0;
        for (int j = 1; j < 128; j += 2) begin
            if (p != 0) begin
                term = longint'(udiv(p, 64'(j)));
                if (alt && j[1]) s = s - term;
                else s = s + term;
                p = udiv(p, nn);
            end
        end
        return s;
    endfunction

    function automatic longint q62_to_q40(input longint v);
        return (v + (64'sd1 <<< 21)) >>> 22;
    endfunction

    function automatic longint pi_q62();
        return 4 * series_recip(5, 1'b1) - series_recip(239, 1'b1);
    endfunction

    function automatic longint atan_q40(input int i);
        if (i == 0) return q62_to_q40(pi_q62());
        return q62_to_q40(series_pow2(i, 1'b1));
    endfunction

    function automatic longint atanh_q40(input int k);
        if (k == 0) return 0;
        return q62_to_q40(series_pow2(k, 1'b0));
    endfunction

    function automatic logic [63:0] f_rad_calc();
        logic [63:0] up;
        logic [63:0] qd;
        logic [63:0] rd;
        up = 64'(pi_q62());
        qd = udiv(up, RAD_DEN);
        rd = up - qd * RAD_DEN;
        return (qd << 10) + udiv((rd << 10) + RAD_HALF, RAD_DEN);
    endfunction

    // floor(2^103 / (pi/4 * 2^62)) = floor(2^43 / pi)
    function automatic logic [63:0] g_inv_calc();
        logic [64:0] r;
        logic [63:0] q;
        logic [63:0] d;
        d = 64'(pi_q62());
        r = '0;
        q = '0;
        for (int b = 103; b >= 0; b--) begin
            r = {r[63:0], (b == 103)};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                if (b < 64) q[b[5:0]] = 1'b1;
            end
        end
        return q;
    endfunction

    // hyperbolic shift for iteration idx; k = 4, 13, 40 run twice
    function automatic int hyp_k(input int idx, input int n);
        int c;
        int res;
        c = 0;
        res = 1;
        for (int k = 1; k <= n; k++) begin
            for (int r = 0; r < 2; r++) begin
                if (r == 0 || k == 4 || k == 13 || k == 40) begin
                    if (c == idx) res = k;
                    c++;
                end
            end
        end
        return res;
    endfunction

    function automatic int hyp_count(input int n);
        return n + int'(n >= 4) + int'(n >= 13) + int'(n >= 40);
    endfunction

    localparam logic [36:0] F_RAD = 37'(f_rad_calc());
    localparam logic [41:0] G_INV = 42'(g_inv_calc());
    localparam logic signed [47:0] LN2_Q40 = 48'(q62_to_q40(2 * series_recip(3, 1'b0)));
    localparam logic signed [CW-1:0] QPI_Q40 = CW'(atan_q40(0));

    // one bit of floor(u * 2^40 / 3.6e9); step 0 yields the integer bit
    function automatic side_t xdiv_step(input side_t s, input int step);
        logic [32:0] t;
        side_t r;
        r = s;
        if (step <= QF) begin
            t = (step == 0) ? {1'b0, s.rem} : {s.rem, 1'b0};
            if (t >= {1'b0, LON_SPAN}) begin
                t = t - {1'b0, LON_SPAN};
                r.xq[QF - step] = 1'b1;
            end
            r.rem = t[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/web_mercator_latlon_to_pixel.sv =====
// Web Mercator lat/lon to global pixel and tile coordinates; uses wmll_pkg.
// Pipeline depth is set mainly by the circular and hyperbolic CORDIC stage chains.
// Throughput: one item per cycle; stalls only ripple into stages that hold data.
// Reset (aresetn, synchronous, active low) clears all stage valid bits; payload is not reset.
module web_mercator_latlon_to_pixel #(
    parameter int MAX_ZOOM      = 23,
    parameter int CORDIC_STAGES = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wmll_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wmll_pkg::out_item_t  m_item
);

    localparam int CW     = wmll_pkg::CW;
    localparam int NC     = CORDIC_STAGES;
    localparam int NH     = wmll_pkg::hyp_count(NC);
    // stage map
    localparam int ST_A   = 0;              // clamp, scale latitude
    localparam int ST_B   = 1;              // radian multiply
    localparam int ST_C   = 2;              // half angle + pi/4
    localparam int ST_CIR = 3;              // circular rotation chain
    localparam int ST_N1  = ST_CIR + NC;    // normalize, coarse
    localparam int ST_N2  = ST_N1 + 1;      // normalize, fine + hyperbolic seed
    localparam int ST_HYP = ST_N2 + 1;      // hyperbolic vectoring chain
    localparam int ST_E1  = ST_HYP + NH;    // exponent * ln2
    localparam int ST_E2  = ST_E1 + 1;      // ln(sin) - ln(cos)
    localparam int ST_E3  = ST_E2 + 1;      // scale by 1/pi
    localparam int ST_E4  = ST_E3 + 1;      // y = 0.5 - t, clamp
    localparam int ST_P1  = ST_E4 + 1;      // round to pixel
    localparam int ST_OUT = ST_P1 + 1;      // edge clamp, output register
    localparam int NS     = ST_OUT + 1;

    localparam logic signed [34:0] LAT_LIM8     = 35'sd8505112878;
    localparam logic signed [34:0] LAT_LIM8_NEG = -35'sd8505112878;
    localparam logic signed [31:0] LON_LIM      = 32'sd1800000000;
    localparam logic signed [31:0] LON_LIM_NEG  = -32'sd1800000000;
    localparam logic signed [CW-1:0] ONE_Q40    = {{(CW-41){1'b0}}, 1'b1, 40'b0};
    localparam logic signed [42:0] HALF_Q40     = {3'b0, 1'b1, 39'b0};
    localparam logic [40:0] ONE_U40             = {1'b1, 40'b0};

    //------------------------------------------------------------------
    // Flow control: a stage loads when it or any stage after it is empty,
    // or when the output is taken. Bubbles get squeezed out, so input keeps
    // flowing while a result sits in the output register.
    //------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;
    logic [NS-1:0] v_in;

    for (genvar i = 0; i < NS; i++) begin : g_en
        assign en[i] = m_ready | ~(&v_reg[NS-1:i]);
    end

    assign v_in    = {v_reg[NS-2:0], s_valid};
    assign s_ready = en[ST_A];
    assign m_valid = v_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) v_reg[i] <= v_in[i];
            end
        end
    end

    //------------------------------------------------------------------
    // Sideband: zoom, clip flag and the x long division, up to two
    // quotient bits per circular stage.
    //------------------------------------------------------------------
    wmll_pkg::side_t side_reg [NS];
    wmll_pkg::side_t side_nx  [NS];

    for (genvar i = 1; i < NS; i++) begin : g_side
        if (i >= ST_CIR && i < ST_CIR + NC) begin : g_div
            assign side_nx[i] = wmll_pkg::xdiv_step(
                wmll_pkg::xdiv_step(side_reg[i-1], 2 * (i - ST_CIR)), 2 * (i - ST_CIR) + 1);
        end else begin : g_pass
            assign side_nx[i] = side_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NS; i++) begin
            if (en[i]) side_reg[i] <= side_nx[i];
        end
    end

    //------------------------------------------------------------------
    // Stage A: latitude to 1e-8 degree, clamp both coordinates
    //------------------------------------------------------------------
    logic signed [34:0] lat35;
    logic signed [34:0] lat8;
    logic signed [34:0] lat8c;
    logic signed [34:0] lat_abs;
    logic signed [31:0] lon_c;
    logic               lat_clip;
    logic               lon_clip;
    logic        [32:0] u33;
    logic        [4:0]  zsat;
    logic        [32:0] mag_reg;
    logic               aneg_reg;

    always_comb begin
        lat35 = 35'($signed(s_item.latitude));
        lat8  = (lat35 <<< 3) + (lat35 <<< 1);
        lat8c = lat8;
        lat_clip = 1'b0;
        if (lat8 > LAT_LIM8) begin
            lat8c = LAT_LIM8;
            lat_clip = 1'b1;
        end else if (lat8 < LAT_LIM8_NEG) begin
            lat8c = LAT_LIM8_NEG;
            lat_clip = 1'b1;
        end
        lat_abs = lat8c[34] ? -lat8c : lat8c;
        lon_c = $signed(s_item.longitude);
        lon_clip = 1'b0;
        if ($signed(s_item.longitude) > LON_LIM) begin
            lon_c = LON_LIM;
            lon_clip = 1'b1;
        end else if ($signed(s_item.longitude) < LON_LIM_NEG) begin
            lon_c = LON_LIM_NEG;
            lon_clip = 1'b1;
        end
        u33  = 33'(lon_c) + 33'(LON_LIM);
        zsat = (s_item.zoom > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : s_item.zoom;
        side_nx[ST_A] = '{zm: zsat, clip: lat_clip | lon_clip, rem: u33[31:0], xq: '0};
    end

    always_ff @(posedge aclk) begin
        if (en[ST_A]) begin
            mag_reg  <= lat_abs[32:0];
            aneg_reg <= lat8c[34];
        end
    end

    //------------------------------------------------------------------
    // Stage B: degrees to radians (split multiply, 17 and 16 bit halves)
    //------------------------------------------------------------------
    logic [53:0] phi_reg;
    logic [52:0] plo_reg;
    logic        bneg_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_B]) begin
            phi_reg  <= 54'(mag_reg[32:16]) * 54'(wmll_pkg::F_RAD);
            plo_reg  <= 53'(mag_reg[15:0]) * 53'(wmll_pkg::F_RAD);
            bneg_reg <= aneg_reg;
        end
    end

    //------------------------------------------------------------------
    // Stage C: angle a = pi/4 + lat/2, seed circular CORDIC
    //------------------------------------------------------------------
    logic [40:0]          half_u;
    logic signed [CW-1:0] half_s;
    logic signed [CW-1:0] cx_reg [0:NC];
    logic signed [CW-1:0] cy_reg [0:NC];
    logic signed [CW-1:0] cz_reg [0:NC];

    assign half_u = 41'(phi_reg >> 14) + 41'(plo_reg >> 30);
    assign half_s = $signed({{(CW-41){1'b0}}, half_u});

    always_ff @(posedge aclk) begin
        if (en[ST_C]) begin
            cx_reg[0] <= ONE_Q40;
            cy_reg[0] <= '0;
            cz_reg[0] <= wmll_pkg::QPI_Q40 + (bneg_reg ? -half_s : half_s);
        end
    end

    //------------------------------------------------------------------
    // Circular rotation: gives K*cos(a), K*sin(a); gain cancels in the ratio
    //------------------------------------------------------------------
    for (genvar i = 0; i < NC; i++) begin : g_cir
        localparam logic signed [CW-1:0] ATAN_I = CW'(wmll_pkg::atan_q40(i));
        always_ff @(posedge aclk) begin
            if (en[ST_CIR + i]) begin
                if (!cz_reg[i][CW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - ATAN_I;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + ATAN_I;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Normalize sin (path 0) and cos (path 1) to [1,2) for the log.
    // Leading one goes to bit 42; mantissa = bits 42:2, exponent = 2 - shift.
    //------------------------------------------------------------------
    logic signed [CW-1:0] cres [0:1];
    logic [42:0] w1_next [0:1];
    logic [5:0]  l1_next [0:1];
    logic [42:0] w2_next [0:1];
    logic [5:0]  l2_next [0:1];
    logic [42:0] nw_reg  [0:1];
    logic [5:0]  nl_reg  [0:1];

    assign cres[0] = cy_reg[NC];
    assign cres[1] = cx_reg[NC];

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            // non-positive result taken as one ulp
            w1_next[p] = (cres[p][CW-1] || cres[p] == '0) ? 43'd1 : cres[p][42:0];
            l1_next[p] = '0;
            if (w1_next[p][42:11] == '0) begin
                w1_next[p] = w1_next[p] << 32;
                l1_next[p] = l1_next[p] + 6'd32;
            end
            if (w1_next[p][42:27] == '0) begin
                w1_next[p] = w1_next[p] << 16;
                l1_next[p] = l1_next[p] + 6'd16;
            end
            if (w1_next[p][42:35] == '0) begin
                w1_next[p] = w1_next[p] << 8;
                l1_next[p] = l1_next[p] + 6'd8;
            end
            w2_next[p] = nw_reg[p];
            l2_next[p] = nl_reg[p];
            if (w2_next[p][42:39] == '0) begin
                w2_next[p] = w2_next[p] << 4;
                l2_next[p] = l2_next[p] + 6'd4;
            end
            if (w2_next[p][42:41] == '0) begin
                w2_next[p] = w2_next[p] << 2;
                l2_next[p] = l2_next[p] + 6'd2;
            end
            if (!w2_next[p][42]) begin
                w2_next[p] = w2_next[p] << 1;
                l2_next[p] = l2_next[p] + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_N1]) begin
            for (int p = 0; p < 2; p++) begin
                nw_reg[p] <= w1_next[p];
                nl_reg[p] <= l1_next[p];
            end
        end
    end

    //------------------------------------------------------------------
    // Hyperbolic vectoring from (M+1, M-1): z -> ln(M)/2
    //------------------------------------------------------------------
    logic signed [CW-1:0] hx_reg [0:NH][0:1];
    logic signed [CW-1:0] hy_reg [0:NH][0:1];
    logic signed [CW-1:0] hz_reg [0:NH][0:1];
    logic signed [6:0]    he_reg [0:NH][0:1];

    always_ff @(posedge aclk) begin
        if (en[ST_N2]) begin
            for (int p = 0; p < 2; p++) begin
                hx_reg[0][p] <= $signed({{(CW-41){1'b0}}, w2_next[p][42:2]}) + ONE_Q40;
                hy_reg[0][p] <= $signed({{(CW-41){1'b0}}, w2_next[p][42:2]}) - ONE_Q40;
                hz_reg[0][p] <= '0;
                he_reg[0][p] <= 7'sd2 - $signed({1'b0, l2_next[p]});
            end
        end
    end

    for (genvar j = 0; j < NH; j++) begin : g_hyp
        localparam int K = wmll_pkg::hyp_k(j, NC);
        localparam logic signed [CW-1:0] ATANH_K = CW'(wmll_pkg::atanh_q40(K));
        always_ff @(posedge aclk) begin
            if (en[ST_HYP + j]) begin
                for (int p = 0; p < 2; p++) begin
                    if (!hy_reg[j][p][CW-1]) begin
                        hx_reg[j+1][p] <= hx_reg[j][p] - (hy_reg[j][p] >>> K);
                        hy_reg[j+1][p] <= hy_reg[j][p] - (hx_reg[j][p] >>> K);
                        hz_reg[j+1][p] <= hz_reg[j][p] + ATANH_K;
                    end else begin
                        hx_reg[j+1][p] <= hx_reg[j][p] + (hy_reg[j][p] >>> K);
                        hy_reg[j+1][p] <= hy_reg[j][p] + (hx_reg[j][p] >>> K);
                        hz_reg[j+1][p] <= hz_reg[j][p] - ATANH_K;
                    end
                    he_reg[j+1][p] <= he_reg[j][p];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // ln = 2z + e*ln2; L = ln(sin) - ln(cos) = atanh(sin lat)
    //------------------------------------------------------------------
    logic signed [CW-1:0] ez_reg [0:1];
    logic signed [47:0]   ep_reg [0:1];
    logic signed [47:0]   lv;
    logic signed [47:0]   labs;
    logic [41:0]          lm_reg;
    logic                 lneg_reg;
    logic [62:0]          mh_reg;
    logic [62:0]          ml_reg;
    logic                 mneg_reg;

    assign lv   = (48'(ez_reg[0]) <<< 1) + ep_reg[0] - (48'(ez_reg[1]) <<< 1) - ep_reg[1];
    assign labs = lv[47] ? -lv : lv;

    always_ff @(posedge aclk) begin
        if (en[ST_E1]) begin
            for (int p = 0; p < 2; p++) begin
                ez_reg[p] <= hz_reg[NH][p];
                ep_reg[p] <= 48'(he_reg[NH][p]) * wmll_pkg::LN2_Q40;
            end
        end
        if (en[ST_E2]) begin
            lm_reg   <= labs[41:0];
            lneg_reg <= lv[47];
        end
        if (en[ST_E3]) begin
            mh_reg   <= 63'(lm_reg[41:21]) * 63'(wmll_pkg::G_INV);
            ml_reg   <= 63'(lm_reg[20:0]) * 63'(wmll_pkg::G_INV);
            mneg_reg <= lneg_reg;
        end
    end

    //------------------------------------------------------------------
    // y = 0.5 - L/(2*pi), clamped to [0, 1]
    //------------------------------------------------------------------
    logic [40:0]        t41;
    logic signed [42:0] ys;
    logic [40:0]        vy_next;
    logic [40:0]        vy_reg;

    always_comb begin
        t41 = 41'(mh_reg >> 23) + 41'(ml_reg >> 44);
        ys  = mneg_reg ? HALF_Q40 + $signed({2'b0, t41}) : HALF_Q40 - $signed({2'b0, t41});
        priority if (ys[42]) begin
            vy_next = '0;
        end else if (ys[41:0] > {1'b0, ONE_U40}) begin
            vy_next = ONE_U40;
        end else begin
            vy_next = ys[40:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_E4]) vy_reg <= vy_next;
    end

    //------------------------------------------------------------------
    // Pixel = floor(v * 2^(8+zoom) + 0.5), then clamp to map edge
    //------------------------------------------------------------------
    function automatic logic [31:0] pix_round(input logic [40:0] v, input logic [4:0] zm);
        logic [40:0] vc;
        logic [41:0] sum;
        vc  = (v > ONE_U40) ? ONE_U40 : v;
        sum = {1'b0, vc} + (42'd1 << (5'd31 - zm));
        return 32'(sum >> (6'd32 - {1'b0, zm}));
    endfunction

    function automatic logic [30:0] pix_clamp(input logic [31:0] p, input logic [4:0] zm);
        logic [31:0] top;
        top = (32'd1 << (6'd8 + {1'b0, zm})) - 32'd1;
        return (p > top) ? top[30:0] : p[30:0];
    endfunction

    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [30:0] px_c;
    logic [30:0] py_c;

    assign px_c = pix_clamp(px_reg, side_reg[ST_P1].zm);
    assign py_c = pix_clamp(py_reg, side_reg[ST_P1].zm);

    always_ff @(posedge aclk) begin
        if (en[ST_P1]) begin
            px_reg <= pix_round(side_reg[ST_E4].xq, side_reg[ST_E4].zm);
            py_reg <= pix_round(vy_reg, side_reg[ST_E4].zm);
        end
        if (en[ST_OUT]) begin
            m_item.pixel_x <= px_c;
            m_item.pixel_y <= py_c;
            m_item.tile_x  <= px_c[30:8];
            m_item.tile_y  <= py_c[30:8];
            m_item.clipped <= side_reg[ST_P1].clip;
        end
    end

endmodule
